[hdl/rqns_pkg.sv]
package rqns_pkg;

	// accumulator start values
	localparam logic [1:0] AI_ZERO  = 2'd0;
	localparam logic [1:0] AI_MINUS = 2'd1;
	localparam logic [1:0] AI_GDIFF = 2'd2;

	// operand of the measure pipe
	localparam logic [2:0] BX_WHOLE = 3'd0;
	localparam logic [2:0] BX_UNION = 3'd1;
	localparam logic [2:0] BX_A     = 3'd2;
	localparam logic [2:0] BX_B     = 3'd3;
	localparam logic [2:0] BX_C0    = 3'd4;
	localparam logic [2:0] BX_C1    = 3'd5;
	localparam logic [2:0] BX_COVG  = 3'd6;

	// source of read address A
	localparam logic [1:0] AS_CTL  = 2'd0;
	localparam logic [1:0] AS_S0   = 2'd1;
	localparam logic [1:0] AS_S1   = 2'd2;
	localparam logic [1:0] AS_PICK = 2'd3;

	// group select
	localparam logic [1:0] GS_0    = 2'd0;
	localparam logic [1:0] GS_1    = 2'd1;
	localparam logic [1:0] GS_BEST = 2'd2;

	typedef struct packed {
		logic       ld;
		logic       lat;
		logic [1:0] a_src;
		logic       acc_load;
		logic [1:0] acc_init;
		logic       feed;
		logic [2:0] box;
		logic       neg;
		logic       take_worst;
		logic       judge_pair;
		logic       scan_init;
		logic       judge_scan;
		logic       asg_cov;
		logic       store_gm;
		logic [1:0] gsel;
		logic       fill_rest;
		logic       single;
		logic       clear;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic loop_go;
		logic assigned_a;
		logic grp_a;
		logic start;
	} sts_t;

endpackage

[hdl/rqns_ram.sv]
module rqns_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

[hdl/rqns_dp.sv]
module rqns_dp #(
	parameter int MAX_ENTRIES = 16,
	parameter int COORD_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rqns_pkg::cmd_t                       cmd,
	output rqns_pkg::sts_t                       sts,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0]     addr_a,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0]     addr_b,
	output logic [$clog2(MAX_ENTRIES+2)-1:0]     total,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [3:0]                           cfg_data,
	input  logic signed [15:0]                   x_low,
	input  logic signed [15:0]                   y_low,
	input  logic signed [15:0]                   x_high,
	input  logic signed [15:0]                   y_high,
	input  logic                                 level_is_branch,
	input  logic                                 last_entry
);

	localparam int CB  = COORD_BITS;
	localparam int SET = MAX_ENTRIES + 1;
	localparam int IW  = $clog2(SET);
	localparam int CW  = $clog2(SET + 1);
	localparam int BW  = 4 * CB;
	localparam int MW  = 2 * CB + 2;
	localparam int WW  = 2 * CB + 4;
	localparam int LW  = CW + 6;

	function automatic logic [CB-1:0] ext(input logic [15:0] v);
		logic [CB+15:0] w;
		w = {{CB{1'b0}}, v};
		return w[CB-1:0];
	endfunction

	function automatic logic [BW-1:0] combine(input logic [BW-1:0] a, input logic [BW-1:0] b);
		logic signed [CB-1:0] axl, ayl, axh, ayh, bxl, byl, bxh, byh, cxl, cyl, cxh, cyh;
		axl = a[CB-1:0];     ayl = a[2*CB-1:CB];
		axh = a[3*CB-1:2*CB]; ayh = a[4*CB-1:3*CB];
		bxl = b[CB-1:0];     byl = b[2*CB-1:CB];
		bxh = b[3*CB-1:2*CB]; byh = b[4*CB-1:3*CB];
		cxl = (axl < bxl) ? axl : bxl;
		cyl = (ayl < byl) ? ayl : byl;
		cxh = (axh > bxh) ? axh : bxh;
		cyh = (ayh > byh) ? ayh : byh;
		if (axl > axh) begin
			return b;
		end else if (bxl > bxh) begin
			return a;
		end
		return {cyh, cxh, cyl, cxl};
	endfunction

	logic [CW-1:0]   cnt_q;
	logic [3:0]      mf_branch_q, mf_leaf_q, minfill_q;
	logic [BW-1:0]   whole_q, ra_q, rb_q, new_box;
	logic [IW-1:0]   ia_q, ib_q, rd_ia_q, rd_ib_q, a_res;
	logic [BW-1:0]   cov_q [2];
	logic [MW-1:0]   gm_q [2];
	logic [CW-1:0]   gcnt_q [2];
	logic [SET-1:0]  assigned_q, grp_q;
	logic signed [WW-1:0] worst_q, best_q, acc_q, d_abs;
	logic [IW-1:0]   s0_q, s1_q, chosen_q;
	logic            better_q, g_sel, d_neg, fill_g;
	logic [BW-1:0]   rdata_a, rdata_b, op_box;
	logic signed [CB:0]   dx, dy, dx_s1, dy_s1;
	logic            v_s1, v_s2, neg_s1, neg_s2;
	logic [2*CB:0]   sqx_s2, sqy_s2;
	logic signed [2*CB+1:0] px, py;
	logic [MW-1:0]   msum;
	logic signed [LW-1:0] lim, c0s, c1s, sums;

	assign new_box = {ext(y_high), ext(x_high), ext(y_low), ext(x_low)};
	assign total   = cnt_q;

	always_comb begin
		case (cmd.a_src)
			rqns_pkg::AS_S0:   a_res = s0_q;
			rqns_pkg::AS_S1:   a_res = s1_q;
			rqns_pkg::AS_PICK: a_res = chosen_q;
			default:           a_res = addr_a;
		endcase
		case (cmd.gsel)
			rqns_pkg::GS_1:    g_sel = 1'b1;
			rqns_pkg::GS_BEST: g_sel = better_q;
			default:           g_sel = 1'b0;
		endcase
	end

	rqns_ram #(.WIDTH(BW), .DEPTH(SET)) u_store (
		.clk     (clk),
		.we      (cmd.ld),
		.waddr   (cnt_q[IW-1:0]),
		.wdata   (new_box),
		.raddr_a (a_res),
		.raddr_b (addr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// fill limits
	always_comb begin
		lim    = LW'(cnt_q) - LW'(minfill_q);
		c0s    = LW'(gcnt_q[0]);
		c1s    = LW'(gcnt_q[1]);
		sums   = c0s + c1s;
		fill_g = (c0s >= lim);
		sts.loop_go    = (sums < LW'(cnt_q)) && (c0s < lim) && (c1s < lim);
		sts.busy       = v_s1 | v_s2;
		sts.assigned_a = assigned_q[a_res];
		sts.grp_a      = grp_q[a_res];
		sts.start      = last_entry || (cnt_q == CW'(SET - 1));
	end

	// measure operand
	always_comb begin
		case (cmd.box)
			rqns_pkg::BX_UNION: op_box = combine(ra_q, rb_q);
			rqns_pkg::BX_A:     op_box = ra_q;
			rqns_pkg::BX_B:     op_box = rb_q;
			rqns_pkg::BX_C0:    op_box = combine(ra_q, cov_q[0]);
			rqns_pkg::BX_C1:    op_box = combine(ra_q, cov_q[1]);
			rqns_pkg::BX_COVG:  op_box = cov_q[g_sel];
			default:            op_box = whole_q;
		endcase
		dx = $signed({op_box[3*CB-1], op_box[3*CB-1:2*CB]})
			- $signed({op_box[CB-1], op_box[CB-1:0]});
		dy = $signed({op_box[4*CB-1], op_box[4*CB-1:3*CB]})
			- $signed({op_box[2*CB-1], op_box[2*CB-1:CB]});
		px = dx_s1 * dx_s1;
		py = dy_s1 * dy_s1;
		msum = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		d_neg = acc_q[WW-1];
		d_abs = d_neg ? -acc_q : acc_q;
	end

	always_ff @(posedge clk) begin
		dx_s1  <= dx;
		dy_s1  <= dy;
		neg_s1 <= cmd.neg;
		sqx_s2 <= px[2*CB:0];
		sqy_s2 <= py[2*CB:0];
		neg_s2 <= neg_s1;
		rd_ia_q <= a_res;
		rd_ib_q <= addr_b;
		if (cmd.ld) begin
			whole_q   <= (cnt_q == '0) ? new_box : combine(whole_q, new_box);
			minfill_q <= level_is_branch ? mf_branch_q : mf_leaf_q;
		end
		if (cmd.lat) begin
			ra_q <= rdata_a;
			rb_q <= rdata_b;
			ia_q <= rd_ia_q;
			ib_q <= rd_ib_q;
		end
		if (cmd.asg_cov) begin
			cov_q[g_sel] <= (gcnt_q[g_sel] == '0) ? ra_q : combine(ra_q, cov_q[g_sel]);
		end
		if (cmd.acc_load) begin
			case (cmd.acc_init)
				rqns_pkg::AI_MINUS: acc_q <= -WW'(1);
				rqns_pkg::AI_GDIFF: acc_q <= WW'(gm_q[0]) - WW'(gm_q[1]);
				default:            acc_q <= '0;
			endcase
		end else if (v_s2) begin
			acc_q <= neg_s2 ? acc_q - WW'(msum) : acc_q + WW'(msum);
		end
		if (cmd.take_worst) begin
			worst_q <= acc_q;
			s0_q    <= '0;
			s1_q    <= IW'(1);
		end else if (cmd.judge_pair && (acc_q > worst_q)) begin
			worst_q <= acc_q;
			s0_q    <= ia_q;
			s1_q    <= ib_q;
		end
		if (cmd.scan_init) begin
			best_q   <= -WW'(1);
			chosen_q <= '0;
			better_q <= 1'b0;
		end else if (cmd.judge_scan) begin
			if (d_abs > best_q) begin
				best_q   <= d_abs;
				chosen_q <= ia_q;
				better_q <= d_neg;
			end else if (d_abs == best_q && gcnt_q[d_neg] < gcnt_q[better_q]) begin
				chosen_q <= ia_q;
				better_q <= d_neg;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			mf_branch_q <= 4'd4;
			mf_leaf_q   <= 4'd4;
			assigned_q  <= '0;
			grp_q       <= '0;
			gcnt_q[0]   <= '0;
			gcnt_q[1]   <= '0;
			gm_q[0]     <= '0;
			gm_q[1]     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			v_s1 <= cmd.feed;
			v_s2 <= v_s1;
			if (cfg_we) begin
				if (cfg_index) begin
					mf_leaf_q <= cfg_data;
				end else begin
					mf_branch_q <= cfg_data;
				end
			end
			if (cmd.clear) begin
				cnt_q      <= '0;
				assigned_q <= '0;
				gcnt_q[0]  <= '0;
				gcnt_q[1]  <= '0;
				gm_q[0]    <= '0;
				gm_q[1]    <= '0;
			end else begin
				if (cmd.ld) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (cmd.single) begin
					assigned_q[0] <= 1'b1;
					grp_q[0]      <= 1'b0;
				end
				if (cmd.asg_cov) begin
					gcnt_q[g_sel]    <= gcnt_q[g_sel] + CW'(1);
					assigned_q[ia_q] <= 1'b1;
					grp_q[ia_q]      <= g_sel;
				end
				if (cmd.store_gm) begin
					gm_q[g_sel] <= acc_q[MW-1:0];
				end
				if (cmd.fill_rest) begin
					for (int k = 0; k < SET; k++) begin
						if (!assigned_q[k]) begin
							assigned_q[k] <= 1'b1;
							grp_q[k]      <= fill_g;
						end
					end
				end
			end
		end
	end

endmodule

[hdl/rqns_ctl.sv]
module rqns_ctl #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	output rqns_pkg::cmd_t                   cmd,
	input  rqns_pkg::sts_t                   sts,
	output logic [$clog2(MAX_ENTRIES+1)-1:0] addr_a,
	output logic [$clog2(MAX_ENTRIES+1)-1:0] addr_b,
	input  logic [$clog2(MAX_ENTRIES+2)-1:0] total,
	input  logic                             in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [4:0]                       entry_index,
	output logic                             group,
	output logic                             last_result
);

	localparam int SET = MAX_ENTRIES + 1;
	localparam int IW  = $clog2(SET);
	localparam int CW  = $clog2(SET + 1);

	localparam logic [4:0] ST_LOAD  = 5'd0;
	localparam logic [4:0] ST_START = 5'd1;
	localparam logic [4:0] ST_WWAIT = 5'd2;
	localparam logic [4:0] ST_PRD   = 5'd3;
	localparam logic [4:0] ST_PLAT  = 5'd4;
	localparam logic [4:0] ST_PF0   = 5'd5;
	localparam logic [4:0] ST_PF1   = 5'd6;
	localparam logic [4:0] ST_PF2   = 5'd7;
	localparam logic [4:0] ST_PWAIT = 5'd8;
	localparam logic [4:0] ST_ARD   = 5'd9;
	localparam logic [4:0] ST_ALAT  = 5'd10;
	localparam logic [4:0] ST_ACOV  = 5'd11;
	localparam logic [4:0] ST_AFEED = 5'd12;
	localparam logic [4:0] ST_AWAIT = 5'd13;
	localparam logic [4:0] ST_LOOP  = 5'd14;
	localparam logic [4:0] ST_SCHK  = 5'd15;
	localparam logic [4:0] ST_SLAT  = 5'd16;
	localparam logic [4:0] ST_SF0   = 5'd17;
	localparam logic [4:0] ST_SF1   = 5'd18;
	localparam logic [4:0] ST_SWAIT = 5'd19;
	localparam logic [4:0] ST_OUT   = 5'd20;

	localparam logic [1:0] MD_SEED0 = 2'd0;
	localparam logic [1:0] MD_SEED1 = 2'd1;
	localparam logic [1:0] MD_PICK  = 2'd2;

	logic [4:0]    st_q, st_d;
	logic [IW-1:0] i_q, i_d, j_q, j_d;
	logic [CW-1:0] k_q, k_d;
	logic [1:0]    md_q, md_d;
	logic [1:0]    md_gsel, md_asrc;

	assign in_ready    = (st_q == ST_LOAD);
	assign out_valid   = (st_q == ST_OUT);
	assign entry_index = 5'(k_q);
	assign group       = sts.grp_a;
	assign last_result = (k_q == total - CW'(1));

	always_comb begin
		unique case (md_q)
			MD_SEED0: begin
				md_gsel = rqns_pkg::GS_0;
				md_asrc = rqns_pkg::AS_S0;
			end
			MD_SEED1: begin
				md_gsel = rqns_pkg::GS_1;
				md_asrc = rqns_pkg::AS_S1;
			end
			default: begin
				md_gsel = rqns_pkg::GS_BEST;
				md_asrc = rqns_pkg::AS_PICK;
			end
		endcase
	end

	always_comb begin
		cmd    = '0;
		addr_a = k_q[IW-1:0];
		addr_b = j_q;
		st_d   = st_q;
		i_d    = i_q;
		j_d    = j_q;
		k_d    = k_q;
		md_d   = md_q;
		unique case (st_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.ld = 1'b1;
					if (sts.start) begin
						st_d = ST_START;
					end
				end
			end
			ST_START: begin
				if (total == CW'(1)) begin
					cmd.single = 1'b1;
					k_d  = '0;
					st_d = ST_OUT;
				end else begin
					cmd.acc_load = 1'b1;
					cmd.acc_init = rqns_pkg::AI_MINUS;
					cmd.feed     = 1'b1;
					cmd.box      = rqns_pkg::BX_WHOLE;
					cmd.neg      = 1'b1;
					st_d = ST_WWAIT;
				end
			end
			ST_WWAIT: begin
				if (!sts.busy) begin
					cmd.take_worst = 1'b1;
					i_d  = '0;
					j_d  = IW'(1);
					st_d = ST_PRD;
				end
			end
			ST_PRD: begin
				addr_a = i_q;
				st_d   = ST_PLAT;
			end
			ST_PLAT: begin
				cmd.lat = 1'b1;
				st_d    = ST_PF0;
			end
			ST_PF0: begin
				cmd.acc_load = 1'b1;
				cmd.feed     = 1'b1;
				cmd.box      = rqns_pkg::BX_UNION;
				st_d = ST_PF1;
			end
			ST_PF1: begin
				cmd.feed = 1'b1;
				cmd.box  = rqns_pkg::BX_A;
				cmd.neg  = 1'b1;
				st_d = ST_PF2;
			end
			ST_PF2: begin
				cmd.feed = 1'b1;
				cmd.box  = rqns_pkg::BX_B;
				cmd.neg  = 1'b1;
				st_d = ST_PWAIT;
			end
			ST_PWAIT: begin
				if (!sts.busy) begin
					cmd.judge_pair = 1'b1;
					if (CW'(j_q) == total - CW'(1)) begin
						if (CW'(i_q) == total - CW'(2)) begin
							md_d = MD_SEED0;
							st_d = ST_ARD;
						end else begin
							i_d  = i_q + IW'(1);
							j_d  = i_q + IW'(2);
							st_d = ST_PRD;
						end
					end else begin
						j_d  = j_q + IW'(1);
						st_d = ST_PRD;
					end
				end
			end
			ST_ARD: begin
				cmd.a_src = md_asrc;
				st_d = ST_ALAT;
			end
			ST_ALAT: begin
				cmd.lat = 1'b1;
				st_d = ST_ACOV;
			end
			ST_ACOV: begin
				cmd.asg_cov = 1'b1;
				cmd.gsel    = md_gsel;
				st_d = ST_AFEED;
			end
			ST_AFEED: begin
				cmd.acc_load = 1'b1;
				cmd.feed     = 1'b1;
				cmd.box      = rqns_pkg::BX_COVG;
				cmd.gsel     = md_gsel;
				st_d = ST_AWAIT;
			end
			ST_AWAIT: begin
				cmd.gsel = md_gsel;
				if (!sts.busy) begin
					cmd.store_gm = 1'b1;
					if (md_q == MD_SEED0) begin
						md_d = MD_SEED1;
						st_d = ST_ARD;
					end else begin
						st_d = ST_LOOP;
					end
				end
			end
			ST_LOOP: begin
				k_d = '0;
				if (sts.loop_go) begin
					cmd.scan_init = 1'b1;
					st_d = ST_SCHK;
				end else begin
					cmd.fill_rest = 1'b1;
					st_d = ST_OUT;
				end
			end
			ST_SCHK: begin
				// the read of entry k is issued here; skip placed entries
				if (k_q == total) begin
					md_d = MD_PICK;
					st_d = ST_ARD;
				end else if (sts.assigned_a) begin
					k_d = k_q + CW'(1);
				end else begin
					st_d = ST_SLAT;
				end
			end
			ST_SLAT: begin
				cmd.lat = 1'b1;
				st_d = ST_SF0;
			end
			ST_SF0: begin
				cmd.acc_load = 1'b1;
				cmd.acc_init = rqns_pkg::AI_GDIFF;
				cmd.feed     = 1'b1;
				cmd.box      = rqns_pkg::BX_C1;
				st_d = ST_SF1;
			end
			ST_SF1: begin
				cmd.feed = 1'b1;
				cmd.box  = rqns_pkg::BX_C0;
				cmd.neg  = 1'b1;
				st_d = ST_SWAIT;
			end
			ST_SWAIT: begin
				if (!sts.busy) begin
					cmd.judge_scan = 1'b1;
					k_d  = k_q + CW'(1);
					st_d = ST_SCHK;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					if (last_result) begin
						cmd.clear = 1'b1;
						st_d = ST_LOAD;
					end else begin
						k_d = k_q + CW'(1);
					end
				end
			end
			default: begin
				st_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			i_q  <= '0;
			j_q  <= '0;
			k_q  <= '0;
			md_q <= MD_SEED0;
		end else begin
			st_q <= st_d;
			i_q  <= i_d;
			j_q  <= j_d;
			k_q  <= k_d;
			md_q <= md_d;
		end
	end

endmodule

[hdl/rtree_quadratic_node_split_core.sv]
// Each rectangle loads as one word while in_ready is high. The seed search sends the
// union, the first and the second box of every pair through the shared measure pipe,
// each placement scans the unplaced entries through that pipe and then places the pick,
// and results leave one word per cycle while out_ready is high, then the next set loads.
// Reset is asynchronous and clears the controller, the set and both fill registers to 4.
module rtree_quadratic_node_split_core #(
	parameter int MAX_ENTRIES = 16,
	parameter int COORD_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] x_low,
	input  logic signed [15:0] y_low,
	input  logic signed [15:0] x_high,
	input  logic signed [15:0] y_high,
	input  logic               level_is_branch,
	input  logic               last_entry,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         entry_index,
	output logic               group,
	output logic               last_result
);

	rqns_pkg::cmd_t cmd;
	rqns_pkg::sts_t sts;
	logic [$clog2(MAX_ENTRIES+1)-1:0] addr_a, addr_b;
	logic [$clog2(MAX_ENTRIES+2)-1:0] total;

	rqns_ctl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.addr_a      (addr_a),
		.addr_b      (addr_b),
		.total       (total),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.entry_index (entry_index),
		.group       (group),
		.last_result (last_result)
	);

	rqns_dp #(.MAX_ENTRIES(MAX_ENTRIES), .COORD_BITS(COORD_BITS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.addr_a          (addr_a),
		.addr_b          (addr_b),
		.total           (total),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.x_low           (x_low),
		.y_low           (y_low),
		.x_high          (x_high),
		.y_high          (y_high),
		.level_is_branch (level_is_branch),
		.last_entry      (last_entry)
	);

endmodule
